// ===== rtl/tlpjq_pkg.sv =====
// Shared types, constants and slot arithmetic for the two-level priority job queue.
// Used by tlpjq_ram and two_level_priority_job_queue; depends on nothing.
package tlpjq_pkg;

   localparam int DEPTH   = 128;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 16;
   localparam int PAGES_W = 16;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // id in the low half, page count in the high half
   typedef struct packed {
      logic [PAGES_W-1:0] pages;
      logic [ID_W-1:0]    id;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } ram_req_type;

   // operation codes
   localparam logic [1:0] FN_ENQUEUE = 2'd0;
   localparam logic [1:0] FN_DEQUEUE = 2'd1;
   localparam logic [1:0] FN_SEARCH  = 2'd2;
   localparam logic [1:0] FN_CANCEL  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // (head + off) mod DEPTH; head < DEPTH and off <= DEPTH, so one subtract does it
   function automatic idx_type slot_of(input idx_type head, input cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/tlpjq_ram.sv =====
// Entry store for one queue: one write port, one read port, registered read data.
// Depends on tlpjq_pkg.
module tlpjq_ram (
   input  logic                    clock,
   input  tlpjq_pkg::ram_req_type  req,
   output tlpjq_pkg::entry_type    rd_data
);

   tlpjq_pkg::entry_type mem_ff [tlpjq_pkg::DEPTH];
   tlpjq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/two_level_priority_job_queue.sv =====
// Search and cancel walk the priority queue and then the normal queue, reading one entry
// per cycle through each queue's read port; cancel then moves each entry behind the match
// one slot toward the head to close the gap.
// One item at a time: req_tready is high only while the sequencer idles.
// Reset (synchronous, active high) clears heads, counts, sequencer and rsp_tvalid.
// Entry stores are not cleared; only occupied slots are ever read.
module two_level_priority_job_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] job_id, [31:16] page_count
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] is_priority
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_id, [31:16] out_pages
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] from_priority
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_DEQ   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;

   // captured request
   logic [1:0]                     op_ff, op_in;
   logic [tlpjq_pkg::ID_W-1:0]     id_ff, id_in;
   logic [tlpjq_pkg::PAGES_W-1:0]  pages_ff, pages_in;
   logic                           prio_ff, prio_in;

   // queue pointers
   tlpjq_pkg::idx_type prio_head_ff, prio_head_in;
   tlpjq_pkg::cnt_type prio_count_ff, prio_count_in;
   tlpjq_pkg::idx_type norm_head_ff, norm_head_in;
   tlpjq_pkg::cnt_type norm_count_ff, norm_count_in;

   // walk control: qsel picks the queue being walked (1 = priority)
   logic               qsel_ff, qsel_in;
   tlpjq_pkg::cnt_type k_ff, k_in;
   logic               pend_ff, pend_in;          // a read is in flight
   tlpjq_pkg::cnt_type pend_off_ff, pend_off_in;  // its offset (scan) or target (shift)

   // result being built
   logic [1:0]           res_status_ff, res_status_in;
   logic                 res_fromp_ff, res_fromp_in;
   tlpjq_pkg::entry_type res_entry_ff, res_entry_in;

   // output register
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_tdata_ff, rsp_tdata_in;
   logic [2:0]  rsp_tuser_ff, rsp_tuser_in;

   // memory ports
   tlpjq_pkg::ram_req_type rq;
   logic                   rq_to_prio;
   tlpjq_pkg::ram_req_type prio_req, norm_req;
   tlpjq_pkg::entry_type   prio_rd, norm_rd;

   // selected-queue views
   tlpjq_pkg::idx_type   sel_head;
   tlpjq_pkg::cnt_type   sel_count;
   tlpjq_pkg::entry_type sel_rd;

   assign sel_head  = qsel_ff ? prio_head_ff  : norm_head_ff;
   assign sel_count = qsel_ff ? prio_count_ff : norm_count_ff;
   assign sel_rd    = qsel_ff ? prio_rd       : norm_rd;

   tlpjq_ram u_prio_ram (
      .clock   (clock),
      .req     (prio_req),
      .rd_data (prio_rd)
   );

   tlpjq_ram u_norm_ram (
      .clock   (clock),
      .req     (norm_req),
      .rd_data (norm_rd)
   );

   // at most one store is touched per cycle; route the single request
   assign prio_req = rq_to_prio ? rq : '0;
   assign norm_req = rq_to_prio ? '0 : rq;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      pages_in      = pages_ff;
      prio_in       = prio_ff;
      prio_head_in  = prio_head_ff;
      prio_count_in = prio_count_ff;
      norm_head_in  = norm_head_ff;
      norm_count_in = norm_count_ff;
      qsel_in       = qsel_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      pend_off_in   = pend_off_ff;
      res_status_in = res_status_ff;
      res_fromp_in  = res_fromp_ff;
      res_entry_in  = res_entry_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rq            = '0;
      rq_to_prio    = qsel_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               id_in    = req_tdata[15:0];
               pages_in = req_tdata[31:16];
               op_in    = req_tuser[1:0];
               prio_in  = req_tuser[2];
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            case (op_ff)
               tlpjq_pkg::FN_ENQUEUE: begin
                  res_fromp_in = 1'b0;
                  res_entry_in = '0;
                  rq_to_prio   = prio_ff;
                  rq.wr_data   = '{pages: pages_ff, id: id_ff};
                  if (prio_ff) begin
                     if (prio_count_ff == tlpjq_pkg::CNT_W'(tlpjq_pkg::DEPTH)) begin
                        res_status_in = tlpjq_pkg::ST_FULL;
                     end else begin
                        rq.wr_en      = 1'b1;
                        rq.wr_addr    = tlpjq_pkg::slot_of(prio_head_ff, prio_count_ff);
                        prio_count_in = tlpjq_pkg::CNT_W'(prio_count_ff + 1'b1);
                        res_status_in = tlpjq_pkg::ST_OK;
                     end
                  end else begin
                     if (norm_count_ff == tlpjq_pkg::CNT_W'(tlpjq_pkg::DEPTH)) begin
                        res_status_in = tlpjq_pkg::ST_FULL;
                     end else begin
                        rq.wr_en      = 1'b1;
                        rq.wr_addr    = tlpjq_pkg::slot_of(norm_head_ff, norm_count_ff);
                        norm_count_in = tlpjq_pkg::CNT_W'(norm_count_ff + 1'b1);
                        res_status_in = tlpjq_pkg::ST_OK;
                     end
                  end
                  state_in = S_RESP;
               end
               tlpjq_pkg::FN_DEQUEUE: begin
                  if (prio_count_ff != '0) begin
                     rq_to_prio    = 1'b1;
                     rq.rd_en      = 1'b1;
                     rq.rd_addr    = prio_head_ff;
                     prio_head_in  = tlpjq_pkg::slot_of(prio_head_ff, tlpjq_pkg::CNT_W'(1));
                     prio_count_in = tlpjq_pkg::CNT_W'(prio_count_ff - 1'b1);
                     qsel_in       = 1'b1;
                     state_in      = S_DEQ;
                  end else if (norm_count_ff != '0) begin
                     rq_to_prio    = 1'b0;
                     rq.rd_en      = 1'b1;
                     rq.rd_addr    = norm_head_ff;
                     norm_head_in  = tlpjq_pkg::slot_of(norm_head_ff, tlpjq_pkg::CNT_W'(1));
                     norm_count_in = tlpjq_pkg::CNT_W'(norm_count_ff - 1'b1);
                     qsel_in       = 1'b0;
                     state_in      = S_DEQ;
                  end else begin
                     res_status_in = tlpjq_pkg::ST_EMPTY;
                     res_fromp_in  = 1'b0;
                     res_entry_in  = '0;
                     state_in      = S_RESP;
                  end
               end
               default: begin
                  // search and cancel: walk priority queue first
                  qsel_in  = 1'b1;
                  k_in     = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
            endcase
         end

         S_DEQ: begin
            res_status_in = tlpjq_pkg::ST_OK;
            res_fromp_in  = qsel_ff;
            res_entry_in  = sel_rd;
            state_in      = S_RESP;
         end

         S_SCAN: begin
            // compare last read while issuing the next one
            if (pend_ff && (sel_rd.id == id_ff)) begin
               res_status_in = tlpjq_pkg::ST_OK;
               res_fromp_in  = qsel_ff;
               res_entry_in  = sel_rd;
               if (op_ff == tlpjq_pkg::FN_CANCEL) begin
                  k_in     = tlpjq_pkg::CNT_W'(pend_off_ff + 1'b1);
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end else if (k_ff < sel_count) begin
               rq.rd_en    = 1'b1;
               rq.rd_addr  = tlpjq_pkg::slot_of(sel_head, k_ff);
               pend_in     = 1'b1;
               pend_off_in = k_ff;
               k_in        = tlpjq_pkg::CNT_W'(k_ff + 1'b1);
            end else if (qsel_ff) begin
               qsel_in = 1'b0;
               k_in    = '0;
               pend_in = 1'b0;
            end else begin
               res_status_in = tlpjq_pkg::ST_NOTFOUND;
               res_fromp_in  = 1'b0;
               res_entry_in  = '0;
               state_in      = S_RESP;
            end
         end

         S_SHIFT: begin
            // entry at offset k moves to k-1; the read of the next entry overlaps the write of the last one
            if (pend_ff) begin
               rq.wr_en   = 1'b1;
               rq.wr_addr = tlpjq_pkg::slot_of(sel_head, pend_off_ff);
               rq.wr_data = sel_rd;
            end
            if (k_ff < sel_count) begin
               rq.rd_en    = 1'b1;
               rq.rd_addr  = tlpjq_pkg::slot_of(sel_head, k_ff);
               pend_in     = 1'b1;
               pend_off_in = tlpjq_pkg::CNT_W'(k_ff - 1'b1);
               k_in        = tlpjq_pkg::CNT_W'(k_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
               if (qsel_ff) begin
                  prio_count_in = tlpjq_pkg::CNT_W'(prio_count_ff - 1'b1);
               end else begin
                  norm_count_in = tlpjq_pkg::CNT_W'(norm_count_ff - 1'b1);
               end
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            // wait for a free output register
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = res_entry_ff;
               rsp_tuser_in  = {res_fromp_ff, res_status_ff};
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prio_head_ff  <= '0;
         prio_count_ff <= '0;
         norm_head_ff  <= '0;
         norm_count_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prio_head_ff  <= prio_head_in;
         prio_count_ff <= prio_count_in;
         norm_head_ff  <= norm_head_in;
         norm_count_ff <= norm_count_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      pages_ff      <= pages_in;
      prio_ff       <= prio_in;
      qsel_ff       <= qsel_in;
      k_ff          <= k_in;
      pend_off_ff   <= pend_off_in;
      res_status_ff <= res_status_in;
      res_fromp_ff  <= res_fromp_in;
      res_entry_ff  <= res_entry_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   // ---- assertions ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (prio_count_ff <= tlpjq_pkg::CNT_W'(tlpjq_pkg::DEPTH)) &&
      (norm_count_ff <= tlpjq_pkg::CNT_W'(tlpjq_pkg::DEPTH)))
      else $error("queue count above depth");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in progress");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result raised outside the response state");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
      ((prio_count_ff == $past(prio_count_ff)) ||
       (prio_count_ff == tlpjq_pkg::CNT_W'($past(prio_count_ff) + 1'b1)) ||
       (prio_count_ff == tlpjq_pkg::CNT_W'($past(prio_count_ff) - 1'b1))))
      else $error("priority count moved by more than one");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (k_ff <= sel_count))
      else $error("cancel shift ran past the queue tail");

endmodule
